// ===== hw/rtl/mandelbrot_pixel_escape_top_assert.svh =====
// Assertion macros shared by the Mandelbrot escape-time block.
// Expects signals clk and rst_n in the scope of each use; no other dependencies.
`ifndef MANDELBROT_PIXEL_ESCAPE_TOP_ASSERT_SVH
`define MANDELBROT_PIXEL_ESCAPE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define MPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mpe assertion failed");
// checked property, also active during reset
`define MPE_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mpe assertion failed");
`else
`define MPE_ASSERT(lbl, prop)
`define MPE_ASSERT_NORST(lbl, prop)
`endif
`endif

// ===== hw/rtl/mpe_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// No dependencies; used by mpe_core, the top level and the testbench.
package mpe_pkg;

  // screen geometry and fixed-point format
  localparam int WIDTH     = 480;
  localparam int HEIGHT    = 272;
  localparam int FRAC_BITS = 28;
  localparam int HALF_W    = WIDTH / 2;
  localparam int HALF_H    = HEIGHT / 2;

  // square term width (non-negative), cross term width (signed)
  localparam int SQ_W = 63 - FRAC_BITS;
  localparam int CR_W = 65 - FRAC_BITS;

  // escape threshold: 4.0 in fixed point
  localparam logic [SQ_W:0] ESC_LIMIT = {{(SQ_W - 2){1'b0}}, 3'b100} << FRAC_BITS;

  localparam logic [7:0] ALPHA     = 8'hFF;
  localparam logic [7:0] SHADE_MAX = 8'd255;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_RE  = 3'd0;
  localparam logic [2:0] REG_CENTER_IM  = 3'd1;
  localparam logic [2:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [2:0] REG_MAX_ITER   = 3'd3;
  localparam logic [2:0] REG_SHADE_STEP = 3'd4;

  // reset values of the registers
  localparam logic [31:0] RST_CENTER_RE  = 32'd0;
  localparam logic [31:0] RST_CENTER_IM  = 32'd0;
  localparam logic [27:0] RST_PIXEL_STEP = 28'd2236962;
  localparam logic [15:0] RST_MAX_ITER   = 16'd1;
  localparam logic [7:0]  RST_SHADE_STEP = 8'd255;

  typedef struct packed {
    logic [31:0] center_re;
    logic [31:0] center_im;
    logic [27:0] pixel_step;
    logic [15:0] max_iter;
    logic [7:0]  shade_step;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [15:0] count;
    logic        in_set;
    logic [31:0] argb;
  } res_t;

  // clamp a 40-bit signed value to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mpe_mul.sv =====
// Shared 32x32 signed multiplier with registered product.
// No package dependency; instantiated by mpe_core.
module mpe_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p_r
);

  // product register holds its value while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

// ===== hw/rtl/mpe_core.sv =====
// Sequencer and datapath of the escape-time iteration around one shared multiplier.
// Depends on mpe_pkg, mpe_mul and mandelbrot_pixel_escape_top_assert.svh.
`include "mandelbrot_pixel_escape_top_assert.svh"

module mpe_core (
  input  logic          clk,
  input  logic          rst_n,
  input  mpe_pkg::cfg_t cfg,
  input  logic          start,
  input  logic [8:0]    px,
  input  logic [8:0]    py,
  input  logic          slot_free,
  output logic          idle,
  output logic          res_load,
  output mpe_pkg::res_t res
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MAPX  = 10'b0000000010,
    S_MAPY  = 10'b0000000100,
    S_MAPW  = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_SQIM  = 10'b0000100000,
    S_CROSS = 10'b0001000000,
    S_UPD   = 10'b0010000000,
    S_SHADE = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [8:0]                      x_r, y_r;
  logic signed [31:0]              c_re_r, c_im_r, z_re_r, z_im_r;
  logic signed [31:0]              c_re_nxt, c_im_nxt, z_re_nxt, z_im_nxt;
  logic [mpe_pkg::SQ_W-1:0]        sq_re_r, sq_im_r;
  logic [15:0]                     n_r;
  logic                            inside_r;

  logic                            mul_en;
  logic signed [31:0]              mul_a, mul_b;
  logic signed [63:0]              prod;
  logic signed [31:0]              dx, dy, step_s;
  logic [mpe_pkg::SQ_W-1:0]        sq_now;
  logic                            escape;
  logic signed [mpe_pkg::CR_W-1:0] cross_sh;
  logic [7:0]                      shade;
  logic [31:0]                     argb;

  // offsets from screen center and step as signed operands
  assign dx     = $signed({23'd0, x_r}) - 32'(mpe_pkg::HALF_W);
  assign dy     = $signed({23'd0, y_r}) - 32'(mpe_pkg::HALF_H);
  assign step_s = $signed({4'd0, cfg.pixel_step});

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = z_re_r;
    mul_b  = z_re_r;
    case (state_r)
      S_MAPX: begin
        mul_a = dx;
        mul_b = step_s;
      end
      S_MAPY: begin
        mul_a = dy;
        mul_b = step_s;
      end
      S_CHECK: begin
        mul_a = z_re_r;
        mul_b = z_re_r;
      end
      S_SQIM: begin
        mul_a = z_im_r;
        mul_b = z_im_r;
      end
      S_CROSS: begin
        mul_a = z_re_r;
        mul_b = z_im_r;
      end
      S_SHADE: begin
        mul_a = $signed({16'd0, n_r});
        mul_b = $signed({24'd0, cfg.shade_step});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mpe_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // floor shifts of the product: squares are non-negative, cross keeps its sign
  assign sq_now   = prod[mpe_pkg::FRAC_BITS +: mpe_pkg::SQ_W];
  assign cross_sh = prod[63:mpe_pkg::FRAC_BITS-1];
  assign escape   = ({1'b0, sq_re_r} + {1'b0, sq_now}) > mpe_pkg::ESC_LIMIT;

  // mapped coordinates and z update
  assign c_re_nxt = mpe_pkg::sat32(40'(prod[39:0]) + 40'(signed'(cfg.center_re)));
  assign c_im_nxt = mpe_pkg::sat32(40'(prod[39:0]) + 40'(signed'(cfg.center_im)));
  assign z_im_nxt = mpe_pkg::sat32(40'(cross_sh) + 40'(c_im_r));
  assign z_re_nxt = mpe_pkg::sat32(40'($signed({1'b0, sq_re_r}))
                                 - 40'($signed({1'b0, sq_im_r})) + 40'(c_re_r));

  // colour: shade saturates at full scale, green joins past half the limit
  assign shade = (|prod[23:8]) ? mpe_pkg::SHADE_MAX : prod[7:0];
  always_comb begin
    if (inside_r) begin
      argb = {mpe_pkg::ALPHA, 24'd0};
    end else if (n_r > (cfg.max_iter >> 1)) begin
      argb = {mpe_pkg::ALPHA, shade, shade, 8'd0};
    end else begin
      argb = {mpe_pkg::ALPHA, shade, 16'd0};
    end
  end

  assign idle     = (state_r == S_IDLE);
  assign res_load = (state_r == S_DONE) && slot_free;
  assign res      = '{x: x_r, y: y_r, count: n_r, in_set: inside_r, argb: argb};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_MAPX;
      S_MAPX:  state_nxt = S_MAPY;
      S_MAPY:  state_nxt = S_MAPW;
      S_MAPW:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = (n_r == cfg.max_iter) ? S_DONE : S_SQIM;
      S_SQIM:  state_nxt = S_CROSS;
      S_CROSS: state_nxt = escape ? S_SHADE : S_UPD;
      S_UPD:   state_nxt = S_CHECK;
      S_SHADE: state_nxt = S_DONE;
      S_DONE:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_r <= px;
          y_r <= py;
        end
      end
      S_MAPY: begin
        c_re_r <= c_re_nxt;
      end
      S_MAPW: begin
        c_im_r   <= c_im_nxt;
        z_re_r   <= '0;
        z_im_r   <= '0;
        n_r      <= '0;
        inside_r <= 1'b1;
      end
      S_SQIM: begin
        sq_re_r <= sq_now;
      end
      S_CROSS: begin
        sq_im_r <= sq_now;
        if (escape) begin
          inside_r <= 1'b0;
        end
      end
      S_UPD: begin
        z_re_r <= z_re_nxt;
        z_im_r <= z_im_nxt;
        n_r    <= n_r + 16'd1;
      end
      default: begin
      end
    endcase
  end

  // iteration count never passes the limit while a pixel is in flight
  `MPE_ASSERT(a_count_bound, (state_r != S_IDLE && state_r != S_MAPX && state_r != S_MAPY
                              && state_r != S_MAPW) |-> (n_r <= cfg.max_iter))
  // an inside point reports the full limit
  `MPE_ASSERT(a_inside_count, (state_r == S_DONE && inside_r) |-> (n_r == cfg.max_iter))
  // handing off the result frees the core
  `MPE_ASSERT(a_load_idle, res_load |=> (state_r == S_IDLE))
  // an escape always goes through the shade multiply
  `MPE_ASSERT(a_escape_shade, (state_r == S_CROSS && escape) |=> (state_r == S_SHADE))

endmodule

// ===== hw/rtl/mandelbrot_pixel_escape_top.sv =====
// Top level of the Mandelbrot escape-time pixel engine: registers, ports, result stage.
// Depends on mpe_pkg and mpe_core (which uses mpe_mul).
//
// Use: send one pixel request (in_pixel_x, in_pixel_y) on the input channel; one
// result request comes back on the output channel with the echoed coordinate,
// the escape count, the inside flag and an ARGB8888 colour.
// A request is taken at a clock edge where valid is high and stall is low.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the view center, pixel step, iteration limit and shade step; cfg_ready is
// always high, writes belong in idle periods between pixels.
// Schedule: one shared 32x32 multiplier does all products. After the accept edge
// the core runs coordinate mapping (MAPX, MAPY, MAPW), then each iteration
// (limit check with real square, imaginary square, cross product, z update).
// A point inside after N steps adds one check and the result state before
// out_valid rises. An escape at count K adds both squares, the shade product
// and the result state. in_stall stays high until the core is idle again, so
// the next pixel is taken only after the current one has left the core; the
// result may still wait in the output register.
// If out_stall holds, a finished pixel waits in the core until that drains.
// Reset (rst_n low, synchronous) empties the result stage, idles the core and
// loads the registers with center 0, step 2236962, limit 1, shade step 255.
module mandelbrot_pixel_escape_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_x,
  output logic [8:0]  out_y,
  output logic [15:0] out_escape_count,
  output logic        out_is_inside,
  output logic [31:0] out_argb_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mpe_pkg::cfg_t cfg_r;
  mpe_pkg::res_t res_r;
  mpe_pkg::res_t core_res;
  logic          out_valid_r;
  logic          core_idle;
  logic          core_load;
  logic          slot_free;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_re  <= mpe_pkg::RST_CENTER_RE;
      cfg_r.center_im  <= mpe_pkg::RST_CENTER_IM;
      cfg_r.pixel_step <= mpe_pkg::RST_PIXEL_STEP;
      cfg_r.max_iter   <= mpe_pkg::RST_MAX_ITER;
      cfg_r.shade_step <= mpe_pkg::RST_SHADE_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpe_pkg::REG_CENTER_RE:  cfg_r.center_re  <= cfg_data;
        mpe_pkg::REG_CENTER_IM:  cfg_r.center_im  <= cfg_data;
        mpe_pkg::REG_PIXEL_STEP: cfg_r.pixel_step <= cfg_data[27:0];
        mpe_pkg::REG_MAX_ITER:   cfg_r.max_iter   <= cfg_data[15:0];
        mpe_pkg::REG_SHADE_STEP: cfg_r.shade_step <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = !core_idle;
  assign slot_free = !out_valid_r || !out_stall;

  mpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && core_idle),
    .px        (in_pixel_x),
    .py        (in_pixel_y),
    .slot_free (slot_free),
    .idle      (core_idle),
    .res_load  (core_load),
    .res       (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_load) begin
      res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = res_r.x;
  assign out_y            = res_r.y;
  assign out_escape_count = res_r.count;
  assign out_is_inside    = res_r.in_set;
  assign out_argb_color   = res_r.argb;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for mandelbrot_pixel_escape_top: directed table, then random views.
// Depends on mpe_pkg (types, register indexes, reset values) and the block's RTL.
module tb;
  import mpe_pkg::*;

  localparam int          RANDOM_ITEMS = 1030;
  localparam int          LIMIT_CYCLES = 10_000_000;
  localparam int          TAIL_CYCLES  = 100;
  localparam int          LONG_HOLD    = 500;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [2:0]  REG_SPARE    = 3'd7;
  localparam logic [31:0] OPAQUE_BLACK = {ALPHA, 24'h00_0000};

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum logic [2:0] {VIEW_NORMAL, VIEW_LONG, VIEW_SHORT, VIEW_EXTREME, VIEW_DEEP} view_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [8:0]  x;
    logic [8:0]  y;
    logic        known;
    logic [15:0] count;
    logic        in_set;
    logic [31:0] argb;
    logic [2:0]  idx;
    logic [31:0] data;
  } dir_row_t;

  localparam int N_DIRECTED = 35;

  // kind, x, y, known, count, in set, argb, register index, register data
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_PIXEL, 9'd0,   9'd0,   1'b1, 16'd1,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_PIXEL, 9'd511, 9'd511, 1'b1, 16'd1,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_PIXEL, 9'd479, 9'd271, 1'b1, 16'd1,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'hFFFF_FFFF},
    '{ROW_PIXEL, 9'd240, 9'd136, 1'b1, 16'd1,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_PIXEL, 9'd256, 9'd256, 1'b1, 16'd1,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    // zero iteration limit: no step runs
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_MAX_ITER,   32'h0000_0000},
    '{ROW_PIXEL, 9'd0,   9'd0,   1'b1, 16'd0,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_PIXEL, 9'd511, 9'd0,   1'b1, 16'd0,     1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    // classic view, upper data bits must be ignored
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_RE,  32'hF800_0000},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_IM,  32'h0000_0000},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_PIXEL_STEP, 32'hF022_2222},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_MAX_ITER,   32'hABCD_0014},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SHADE_STEP, 32'h1234_5610},
    '{ROW_PIXEL, 9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd100, 9'd136, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd200, 9'd100, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd240, 9'd136, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd300, 9'd150, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd479, 9'd271, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd511, 9'd511, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd150, 9'd60,  1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SHADE_STEP, 32'h0000_0000},
    '{ROW_PIXEL, 9'd200, 9'd100, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    // saturating coordinate mapping
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_RE,  32'h7FFF_FFFF},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_IM,  32'h8000_0000},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_PIXEL_STEP, 32'h0FFF_FFFF},
    '{ROW_PIXEL, 9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    '{ROW_PIXEL, 9'd511, 9'd511, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0},
    // full iteration limit, origin stays inside
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_RE,  32'h0000_0000},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_CENTER_IM,  32'h0000_0000},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_MAX_ITER,   32'h0000_FFFF},
    '{ROW_CFG,   9'd0,   9'd0,   1'b0, 16'd0,     1'b0, 32'h0, REG_SHADE_STEP, 32'h0000_00FF},
    '{ROW_PIXEL, 9'd240, 9'd136, 1'b1, 16'd65535, 1'b1, OPAQUE_BLACK, REG_SPARE, 32'h0},
    '{ROW_PIXEL, 9'd0,   9'd271, 1'b0, 16'd0,     1'b0, 32'h0, REG_SPARE,      32'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [8:0]  in_pixel_x;
  logic [8:0]  in_pixel_y;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  out_x;
  logic [8:0]  out_y;
  logic [15:0] out_escape_count;
  logic        out_is_inside;
  logic [31:0] out_argb_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // view registers as the block should hold them
  logic signed [31:0] view_center_re = RST_CENTER_RE;
  logic signed [31:0] view_center_im = RST_CENTER_IM;
  logic [27:0]        view_step      = RST_PIXEL_STEP;
  logic [15:0]        iter_limit     = RST_MAX_ITER;
  logic [7:0]         shade_inc      = RST_SHADE_STEP;

  res_t due_results [$];
  int   error_count  = 0;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  bit   hold_request = 1'b0;

  mandelbrot_pixel_escape_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_escape_count (out_escape_count),
    .out_is_inside    (out_is_inside),
    .out_argb_color   (out_argb_color),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // escape-time result of one pixel under the current view
  function automatic res_t escape_pixel(input logic [8:0] px, input logic [8:0] py);
    longint      c_re, c_im, z_re, z_im, sq_re, sq_im, cross_term, esc_bound;
    int unsigned n, shade;
    logic        escaped;
    res_t        r;
    c_re = clamp_s32((longint'(px) - HALF_W) * longint'(view_step) + longint'(view_center_re));
    c_im = clamp_s32((longint'(py) - HALF_H) * longint'(view_step) + longint'(view_center_im));
    esc_bound = longint'(4) <<< FRAC_BITS;
    z_re = 0;
    z_im = 0;
    n = 0;
    escaped = 1'b0;
    while (n < iter_limit && !escaped) begin
      sq_re = (z_re * z_re) >>> FRAC_BITS;
      sq_im = (z_im * z_im) >>> FRAC_BITS;
      if (sq_re + sq_im > esc_bound) begin
        escaped = 1'b1;
      end else begin
        cross_term = (z_re * z_im) >>> (FRAC_BITS - 1);
        z_im = clamp_s32(cross_term + c_im);
        z_re = clamp_s32(sq_re - sq_im + c_re);
        n++;
      end
    end
    shade = n * shade_inc;
    if (shade > 255) shade = 255;
    r.x = px;
    r.y = py;
    r.count = n[15:0];
    r.in_set = !escaped;
    if (!escaped) begin
      r.argb = OPAQUE_BLACK;
    end else if (n > iter_limit / 2) begin
      r.argb = {ALPHA, shade[7:0], shade[7:0], 8'h00};
    end else begin
      r.argb = {ALPHA, shade[7:0], 16'h0000};
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // offer one pixel request, record what it must produce, then pace the next one
  task automatic offer_pixel(input logic [8:0] px, input logic [8:0] py,
                             input logic known, input res_t known_res);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (in_stall);
    due_results.push_back(known ? known_res : escape_pixel(px, py));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_RE:  view_center_re = data;
      REG_CENTER_IM:  view_center_im = data;
      REG_PIXEL_STEP: view_step      = data[27:0];
      REG_MAX_ITER:   iter_limit     = data[15:0];
      REG_SHADE_STEP: shade_inc      = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{x: out_x, y: out_y, count: out_escape_count, in_set: out_is_inside,
              argb: out_argb_color};
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result x=%0d y=%0d count=%0d", got.x, got.y,
                             got.count));
      end else begin
        want = due_results.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.count !== want.count ||
            got.in_set !== want.in_set || got.argb !== want.argb) begin
          flag_error($sformatf(
            {"mismatch: exp x=%0d y=%0d count=%0d in_set=%0b argb=%08h,",
             " got x=%0d y=%0d count=%0d in_set=%0b argb=%08h"},
            want.x, want.y, want.count, want.in_set, want.argb,
            got.x, got.y, got.count, got.in_set, got.argb));
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold on request
  initial begin
    stall_mode_t mode;
    int          seg_left;
    int          tick;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    seg_left  = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 300);
        end
        seg_left--;
        tick++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    logic signed [31:0] c_re_w;
    logic signed [31:0] c_im_w;
    logic [27:0]        step_w;
    logic [15:0]        iter_w;
    logic [7:0]         shade_w;
    logic [31:0]        junk;
    logic [8:0]         px;
    logic [8:0]         py;
    view_t              view;
    int                 pick;
    int                 sent;
    int                 phase_no;
    int                 phase_len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_CENTER_RE;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        offer_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
                    '{x: directed_rows[i].x, y: directed_rows[i].y,
                      count: directed_rows[i].count, in_set: directed_rows[i].in_set,
                      argb: directed_rows[i].argb});
      end
    end

    // random views, each with a burst of pixels
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      pick = $urandom_range(0, 9);
      view = (pick <= 5) ? VIEW_NORMAL : (pick == 6) ? VIEW_LONG : (pick == 7) ? VIEW_SHORT :
             (pick == 8) ? VIEW_EXTREME : VIEW_DEEP;
      c_re_w  = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
      c_im_w  = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      step_w  = 28'($urandom_range(32'h1000, 32'h40_0000));
      iter_w  = 16'($urandom_range(1, 40));
      shade_w = 8'($urandom_range(0, 255));
      junk    = $urandom;
      case (view)
        VIEW_LONG: iter_w = 16'($urandom_range(41, 300));
        VIEW_SHORT: begin
          iter_w = 16'($urandom_range(0, 1));
          c_re_w = $urandom;
          c_im_w = $urandom;
          step_w = 28'($urandom);
        end
        VIEW_EXTREME: begin
          case ($urandom_range(0, 2))
            0: c_re_w = 32'sh7FFF_FFFF;
            1: c_re_w = 32'sh8000_0000;
            default: c_re_w = $urandom;
          endcase
          case ($urandom_range(0, 2))
            0: c_im_w = 32'sh7FFF_FFFF;
            1: c_im_w = 32'sh8000_0000;
            default: c_im_w = $urandom;
          endcase
          case ($urandom_range(0, 2))
            0: step_w = '0;
            1: step_w = 28'hFFF_FFFF;
            default: step_w = 28'($urandom);
          endcase
          shade_w = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
        end
        VIEW_DEEP: begin
          // far right of the plane: every point escapes after the first step despite the high limit
          iter_w = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
          c_re_w = 32'sh7FFF_FFFF;
          step_w = 28'($urandom_range(0, 32'h10_0000));
        end
        default: ;
      endcase
      write_reg(REG_CENTER_RE, c_re_w);
      write_reg(REG_CENTER_IM, c_im_w);
      write_reg(REG_PIXEL_STEP, {junk[31:28], step_w});
      write_reg(REG_MAX_ITER, {junk[15:0], iter_w});
      write_reg(REG_SHADE_STEP, {junk[23:0], shade_w});
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
      // first view: receiver holds off while pixels keep coming
      if (phase_no == 0) hold_request = 1'b1;
      phase_len = $urandom_range(30, 110);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          px = 9'($urandom_range(0, 511));
          py = 9'($urandom_range(0, 511));
        end else begin
          px = 9'($urandom_range(0, WIDTH - 1));
          py = 9'($urandom_range(0, HEIGHT - 1));
        end
        offer_pixel(px, py, 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      phase_no++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
